[sv/two_wire_humidity_sensor_master_assert.svh]
// Assertion macros for the two-wire humidity sensor master checker.
// Needs no package; included by the checker file.
`ifndef TWO_WIRE_HUMIDITY_SENSOR_MASTER_ASSERT_SVH
`define TWO_WIRE_HUMIDITY_SENSOR_MASTER_ASSERT_SVH

// Same-cycle implication.
`define THSM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("thsm assertion failed");

// Next-cycle implication.
`define THSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("thsm assertion failed");

`endif

[sv/thsm_pkg.sv]
// Shared types, codes and sequencer tables for the two-wire sensor master.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package thsm_pkg;

   localparam int RESYNC_CLOCKS = 9;

   typedef logic [3:0] stage_kind_type;

   localparam stage_kind_type K_END    = 4'd0;
   localparam stage_kind_type K_CLOCKS = 4'd1;
   localparam stage_kind_type K_START  = 4'd2;
   localparam stage_kind_type K_WRCMD  = 4'd3;
   localparam stage_kind_type K_WRSTAT = 4'd4;
   localparam stage_kind_type K_WAIT   = 4'd5;
   localparam stage_kind_type K_RD_HI  = 4'd6;
   localparam stage_kind_type K_RD_LO  = 4'd7;
   localparam stage_kind_type K_RD_CK  = 4'd8;
   localparam stage_kind_type K_RD_ST  = 4'd9;

   localparam logic [2:0] OP_IDLE     = 3'd0;
   localparam logic [2:0] OP_TEMP     = 3'd1;
   localparam logic [2:0] OP_HUMID    = 3'd2;
   localparam logic [2:0] OP_STAT_RD  = 3'd3;
   localparam logic [2:0] OP_STAT_WR  = 3'd4;
   localparam logic [2:0] OP_SOFT_RST = 3'd5;
   localparam logic [2:0] OP_RESYNC   = 3'd6;

   localparam logic [2:0] CSR_TEMP_CMD     = 3'd0;
   localparam logic [2:0] CSR_HUMID_CMD    = 3'd1;
   localparam logic [2:0] CSR_STAT_RD_CMD  = 3'd2;
   localparam logic [2:0] CSR_STAT_WR_CMD  = 3'd3;
   localparam logic [2:0] CSR_SOFT_RST_CMD = 3'd4;
   localparam logic [2:0] CSR_WAIT_LIMIT   = 3'd5;

   // start condition waveform, indexed by phase
   localparam logic [6:0] START_SCK  = 7'b0110110;
   localparam logic [6:0] START_DATA = 7'b1100011;

   typedef struct packed {
      logic [2:0] command;
      logic       data_in;
      logic [7:0] status_byte;
   } req_type;

   typedef struct packed {
      logic        sck_level;
      logic        data_release;
      logic        busy_res;
      logic        done_res;
      logic [1:0]  error_count;
      logic [15:0] measured_value;
      logic [7:0]  checksum_byte;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  temp_command_byte;
      logic [7:0]  humidity_command_byte;
      logic [7:0]  status_read_command_byte;
      logic [7:0]  status_write_command_byte;
      logic [7:0]  soft_reset_command_byte;
      logic [15:0] ready_wait_limit;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [4:0]  sequence_step;
      logic [3:0]  phase_count;
      logic [3:0]  bit_index;
      logic [7:0]  shift_byte;
      logic [15:0] wait_count;
      logic [1:0]  errors_seen;
      logic [15:0] value_hold;
      logic [7:0]  checksum_hold;
      logic        sck_out;
      logic        data_out;
   } state_type;

   function automatic stage_kind_type program_kind(input logic [2:0] op,
                                                   input logic [2:0] step);
      stage_kind_type k;
      k = K_END;
      case (op)
         OP_TEMP, OP_HUMID: begin
            case (step)
               3'd0: k = K_START;
               3'd1: k = K_WRCMD;
               3'd2: k = K_WAIT;
               3'd3: k = K_RD_HI;
               3'd4: k = K_RD_LO;
               3'd5: k = K_RD_CK;
               default: k = K_END;
            endcase
         end
         OP_STAT_RD: begin
            case (step)
               3'd0: k = K_START;
               3'd1: k = K_WRCMD;
               3'd2: k = K_RD_ST;
               3'd3: k = K_RD_CK;
               default: k = K_END;
            endcase
         end
         OP_STAT_WR: begin
            case (step)
               3'd0: k = K_START;
               3'd1: k = K_WRCMD;
               3'd2: k = K_WRSTAT;
               default: k = K_END;
            endcase
         end
         OP_SOFT_RST: begin
            case (step)
               3'd0: k = K_CLOCKS;
               3'd1: k = K_START;
               3'd2: k = K_WRCMD;
               default: k = K_END;
            endcase
         end
         OP_RESYNC: begin
            case (step)
               3'd0: k = K_CLOCKS;
               3'd1: k = K_START;
               default: k = K_END;
            endcase
         end
         default: k = K_END;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

[sv/thsm_csr.sv]
// Configuration registers of the two-wire sensor master.
// Depends on thsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module thsm_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic [2:0]       csr_index,
   input  wire logic [15:0]      csr_wdata,
   output thsm_pkg::cfg_type     cfg
);

   thsm_pkg::cfg_type cfg_ff;
   thsm_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            thsm_pkg::CSR_TEMP_CMD:     cfg_in.temp_command_byte         = csr_wdata[7:0];
            thsm_pkg::CSR_HUMID_CMD:    cfg_in.humidity_command_byte     = csr_wdata[7:0];
            thsm_pkg::CSR_STAT_RD_CMD:  cfg_in.status_read_command_byte  = csr_wdata[7:0];
            thsm_pkg::CSR_STAT_WR_CMD:  cfg_in.status_write_command_byte = csr_wdata[7:0];
            thsm_pkg::CSR_SOFT_RST_CMD: cfg_in.soft_reset_command_byte   = csr_wdata[7:0];
            thsm_pkg::CSR_WAIT_LIMIT:   cfg_in.ready_wait_limit          = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_command_byte         <= 8'd3;
         cfg_ff.humidity_command_byte     <= 8'd5;
         cfg_ff.status_read_command_byte  <= 8'd7;
         cfg_ff.status_write_command_byte <= 8'd6;
         cfg_ff.soft_reset_command_byte   <= 8'd30;
         cfg_ff.ready_wait_limit          <= 16'd320;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[sv/thsm_step.sv]
// Next-state and result logic of the bus sequencer: one bus phase per tick.
// Depends on thsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module thsm_step (
   input  thsm_pkg::state_type cur,
   input  thsm_pkg::req_type   req,
   input  thsm_pkg::cfg_type   cfg,
   output thsm_pkg::state_type nxt,
   output thsm_pkg::rsp_type   rsp
);

   thsm_pkg::state_type      nx;
   thsm_pkg::stage_kind_type kind;
   thsm_pkg::stage_kind_type next_kind;
   logic [3:0]               ph;
   logic                     fin;
   logic                     done;

   function automatic logic [7:0] cmd_byte(input logic [2:0] op,
                                           input thsm_pkg::cfg_type c);
      logic [7:0] b;
      case (op)
         thsm_pkg::OP_TEMP:     b = c.temp_command_byte;
         thsm_pkg::OP_HUMID:    b = c.humidity_command_byte;
         thsm_pkg::OP_STAT_RD:  b = c.status_read_command_byte;
         thsm_pkg::OP_STAT_WR:  b = c.status_write_command_byte;
         thsm_pkg::OP_SOFT_RST: b = c.soft_reset_command_byte;
         default: b = 8'd0;
      endcase
      return b;
   endfunction

   function automatic logic [1:0] err_inc(input logic [1:0] e);
      return (e == 2'd3) ? e : e + 2'd1;
   endfunction

   always_comb begin
      nx        = cur;
      fin       = 1'b0;
      done      = 1'b0;
      kind      = thsm_pkg::K_END;
      next_kind = thsm_pkg::K_END;
      ph        = 4'd0;

      // new request, only when idle; its first phase runs in the same tick
      if (nx.operation == thsm_pkg::OP_IDLE && req.command >= thsm_pkg::OP_TEMP &&
          req.command <= thsm_pkg::OP_RESYNC) begin
         nx.operation     = req.command;
         nx.sequence_step = 5'd0;
         nx.errors_seen   = 2'd0;
         nx.checksum_hold = 8'd0;
         nx.value_hold    = (req.command == thsm_pkg::OP_STAT_WR) ?
                            {8'd0, req.status_byte} : 16'd0;
         nx.phase_count   = 4'd0;
         nx.bit_index     = 4'd0;
         nx.wait_count    = 16'd0;
         nx.shift_byte    = 8'd0;
      end

      if (nx.operation != thsm_pkg::OP_IDLE) begin
         kind = thsm_pkg::program_kind(nx.operation, nx.sequence_step[2:0]);
         case (kind)
            thsm_pkg::K_CLOCKS: begin
               nx.data_out = 1'b1;
               if (nx.phase_count == 4'd0) begin
                  nx.sck_out     = 1'b1;
                  nx.phase_count = 4'd1;
               end else begin
                  nx.sck_out     = 1'b0;
                  nx.phase_count = 4'd0;
                  if (({1'b0, nx.bit_index} + 5'd1) >= 5'(thsm_pkg::RESYNC_CLOCKS))
                     fin = 1'b1;
                  else
                     nx.bit_index = nx.bit_index + 4'd1;
               end
            end
            thsm_pkg::K_START: begin
               ph          = (nx.phase_count > 4'd6) ? 4'd6 : nx.phase_count;
               nx.sck_out  = thsm_pkg::START_SCK[ph[2:0]];
               nx.data_out = thsm_pkg::START_DATA[ph[2:0]];
               if (ph == 4'd6) begin
                  nx.phase_count = ph;
                  fin            = 1'b1;
               end else begin
                  nx.phase_count = ph + 4'd1;
               end
            end
            thsm_pkg::K_WRCMD, thsm_pkg::K_WRSTAT: begin
               if (nx.bit_index < 4'd8) begin
                  if (nx.phase_count == 4'd0) begin
                     nx.data_out    = nx.shift_byte[7];
                     nx.sck_out     = 1'b0;
                     nx.phase_count = 4'd1;
                  end else if (nx.phase_count == 4'd1) begin
                     nx.sck_out     = 1'b1;
                     nx.phase_count = 4'd2;
                  end else begin
                     nx.sck_out     = 1'b0;
                     nx.shift_byte  = {nx.shift_byte[6:0], 1'b0};
                     nx.bit_index   = nx.bit_index + 4'd1;
                     nx.phase_count = 4'd0;
                  end
               end else if (nx.phase_count == 4'd0) begin
                  nx.sck_out     = 1'b1;
                  nx.data_out    = 1'b1;
                  nx.phase_count = 4'd1;
               end else begin
                  if (req.data_in)
                     nx.errors_seen = err_inc(nx.errors_seen);
                  nx.sck_out  = 1'b0;
                  nx.data_out = 1'b1;
                  fin         = 1'b1;
               end
            end
            thsm_pkg::K_WAIT: begin
               nx.sck_out  = 1'b0;
               nx.data_out = 1'b1;
               if (!req.data_in) begin
                  fin = 1'b1;
               end else begin
                  nx.wait_count = nx.wait_count + 16'd1;
                  if (nx.wait_count >= cfg.ready_wait_limit) begin
                     nx.errors_seen = err_inc(nx.errors_seen);
                     fin            = 1'b1;
                  end
               end
            end
            thsm_pkg::K_RD_HI, thsm_pkg::K_RD_LO, thsm_pkg::K_RD_CK, thsm_pkg::K_RD_ST: begin
               if (nx.bit_index < 4'd8) begin
                  nx.data_out = 1'b1;
                  if (nx.phase_count == 4'd0) begin
                     nx.sck_out     = 1'b1;
                     nx.phase_count = 4'd1;
                  end else begin
                     nx.sck_out     = 1'b0;
                     nx.shift_byte  = {nx.shift_byte[6:0], req.data_in};
                     nx.bit_index   = nx.bit_index + 4'd1;
                     nx.phase_count = 4'd0;
                  end
               end else if (nx.phase_count == 4'd0) begin
                  // ack low, except no ack after the checksum
                  nx.sck_out     = 1'b0;
                  nx.data_out    = (kind == thsm_pkg::K_RD_CK);
                  nx.phase_count = 4'd1;
               end else if (nx.phase_count == 4'd1) begin
                  nx.sck_out     = 1'b1;
                  nx.phase_count = 4'd2;
               end else begin
                  nx.sck_out = 1'b0;
                  if (kind == thsm_pkg::K_RD_HI)
                     nx.value_hold = {nx.shift_byte, 8'd0};
                  else if (kind == thsm_pkg::K_RD_LO)
                     nx.value_hold = nx.value_hold | {8'd0, nx.shift_byte};
                  else if (kind == thsm_pkg::K_RD_ST)
                     nx.value_hold = {8'd0, nx.shift_byte};
                  else
                     nx.checksum_hold = nx.shift_byte;
                  fin = 1'b1;
               end
            end
            default: begin
               nx.operation     = thsm_pkg::OP_IDLE;
               nx.sequence_step = 5'd0;
               done             = 1'b1;
            end
         endcase

         if (fin) begin
            nx.sequence_step = nx.sequence_step + 5'd1;
            next_kind = thsm_pkg::program_kind(nx.operation, nx.sequence_step[2:0]);
            if (next_kind == thsm_pkg::K_END) begin
               nx.operation     = thsm_pkg::OP_IDLE;
               nx.sequence_step = 5'd0;
               nx.phase_count   = 4'd0;
               nx.bit_index     = 4'd0;
               done             = 1'b1;
            end else begin
               nx.phase_count = 4'd0;
               nx.bit_index   = 4'd0;
               nx.wait_count  = 16'd0;
               if (next_kind == thsm_pkg::K_WRCMD)
                  nx.shift_byte = cmd_byte(nx.operation, cfg);
               else if (next_kind == thsm_pkg::K_WRSTAT)
                  nx.shift_byte = nx.value_hold[7:0];
               else
                  nx.shift_byte = 8'd0;
            end
         end
      end
   end

   assign nxt                = nx;
   assign rsp.sck_level      = nx.sck_out;
   assign rsp.data_release   = nx.data_out;
   assign rsp.busy_res       = (nx.operation != thsm_pkg::OP_IDLE);
   assign rsp.done_res       = done;
   assign rsp.error_count    = nx.errors_seen;
   assign rsp.measured_value = nx.value_hold;
   assign rsp.checksum_byte  = nx.checksum_hold;

endmodule

`default_nettype wire

[sv/two_wire_humidity_sensor_master.sv]
// Top level of the two-wire humidity and temperature sensor bus master.
// Depends on thsm_pkg, thsm_csr and thsm_step.
//
// Each req transfer is one bus phase tick and yields exactly one rsp transfer carrying the
// SCK and DATA levels to drive, busy/done flags, the error count and the last values read.
// The sequencer state and the result both update at the edge that takes a request, so a
// tick is taken in each cycle in which req_valid and req_ready are both high, and its result
// is in the output register from the following cycle; throughput is one tick per cycle,
// and it stalls only while a result waits in the output register with rsp_ready low.
// Commands arriving while busy are ignored. Configuration writes apply on the next cycle.
`timescale 1ns / 1ps
`default_nettype none

module two_wire_humidity_sensor_master (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  thsm_pkg::req_type      req_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output thsm_pkg::rsp_type      rsp_item,
   input  wire logic              csr_we,
   input  wire logic [2:0]        csr_index,
   input  wire logic [15:0]       csr_wdata
);

   thsm_pkg::cfg_type   cfg;
   thsm_pkg::state_type state_ff;
   thsm_pkg::state_type state_in;
   thsm_pkg::rsp_type   rsp_ff;
   thsm_pkg::rsp_type   rsp_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                accept;

   thsm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   thsm_step u_step (
      .cur (state_ff),
      .req (req_item),
      .cfg (cfg),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= '0;
         state_ff.data_out <= 1'b1;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept)
            state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept)
         rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

[sv/thsm_checker.sv]
// Port-level checker for the two-wire sensor master, bound to the top level.
// Depends on thsm_pkg and two_wire_humidity_sensor_master_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "two_wire_humidity_sensor_master_assert.svh"

module thsm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input thsm_pkg::rsp_type rsp_item
);

   `THSM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_item))
   `THSM_ASSERT_NOW(a_done_not_busy, clock, reset, rsp_valid && rsp_item.done_res, !rsp_item.busy_res)
   `THSM_ASSERT_NOW(a_idle_bus, clock, reset, rsp_valid && !rsp_item.busy_res, !rsp_item.sck_level && rsp_item.data_release)
   `THSM_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)

endmodule

bind two_wire_humidity_sensor_master thsm_checker u_thsm_checker (.*);

`default_nettype wire
